// ===== design/dq_pkg.sv =====
// Shared types and constants for the bounded deque.
// Depends on nothing; imported by the bounded_deque top level and the testbench.
`default_nettype none

package dq_pkg;

  // Capacity and derived widths
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  // Output beat packing
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } dq_kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } dq_status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } dq_state_e;

  // Ring slot at base + off, both below DEPTH
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (ADDR_W+1)'(DEPTH)) begin
      sum = sum - (ADDR_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/bounded_deque.sv =====
// Bounded deque: pushes and refused operations produce their result beat in
// the cycle after accept; successful pops go through the read state, where the
// new end word is merged from the ring RAM's registered read, and take no input.
// Throughput: one push or refused operation per cycle while results are taken.
// Reset clears head pointer, count and cached end words; RAM contents are
// left as they are and are never read before being written.
`default_nettype none

module bounded_deque
  import dq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [WORD_W-1:0]     s_axis_tdata_i,  // [31:0] value
  input  wire logic [KIND_W-1:0]     s_axis_tuser_i,  // [1:0] kind
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // [31:0] popped_value, [42:32] count, [74:43] front_value,
  // [106:75] back_value, [111:107] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // [1:0] status, [2] not_empty
  output logic [OUT_USER_W-1:0]      m_axis_tuser_o
);

  // Control state
  dq_state_e         state_q, state_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              front_take_q, front_take_d;

  // Cached end words and pending popped word
  logic [WORD_W-1:0] front_q, front_d;
  logic [WORD_W-1:0] back_q, back_d;
  logic [WORD_W-1:0] popped_q, popped_d;

  // Output register
  logic              out_valid_q;
  logic              load_out;
  logic [STAT_W-1:0] o_status_q, o_status_d;
  logic [WORD_W-1:0] o_popped_q, o_popped_d;
  logic [CNT_W-1:0]  o_count_q, o_count_d;
  logic              o_nempty_q, o_nempty_d;
  logic [WORD_W-1:0] o_front_q, o_front_d;
  logic [WORD_W-1:0] o_back_q, o_back_d;

  // RAM port signals
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              accept;
  logic              full, empty;
  dq_kind_e          kind;

  assign kind   = dq_kind_e'(s_axis_tuser_i);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Take a new beat only when idle and the output slot is free or draining
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind[1] && !empty) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs: update pointers, issue RAM access, build the result
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    front_take_d = front_take_q;
    front_d      = front_q;
    back_d       = back_q;
    popped_d     = popped_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = ring_add(head_q, count_q[ADDR_W-1:0]);
    ram_raddr    = ring_add(head_q, ADDR_W'(1));
    load_out     = 1'b0;
    o_status_d   = STAT_OK;
    o_popped_d   = '0;
    o_count_d    = count_q;
    o_nempty_d   = !empty;
    o_front_d    = empty ? '0 : front_q;
    o_back_d     = empty ? '0 : back_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                o_status_d = STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CNT_W'(1);
                if (kind == KIND_PUSH_FRONT) begin
                  head_d    = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - ADDR_W'(1);
                  ram_waddr = head_d;
                  front_d   = s_axis_tdata_i;
                  back_d    = empty ? s_axis_tdata_i : back_q;
                end else begin
                  front_d = empty ? s_axis_tdata_i : front_q;
                  back_d  = s_axis_tdata_i;
                end
                o_count_d  = count_d;
                o_nempty_d = 1'b1;
                o_front_d  = front_d;
                o_back_d   = back_d;
              end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
              if (empty) begin
                load_out   = 1'b1;
                o_status_d = STAT_EMPTY;
              end else begin
                // Fetch the word that becomes the new end
                ram_re       = 1'b1;
                count_d      = count_q - CNT_W'(1);
                front_take_d = (kind == KIND_POP_FRONT);
                if (kind == KIND_POP_FRONT) begin
                  popped_d  = front_q;
                  head_d    = ring_add(head_q, ADDR_W'(1));
                  ram_raddr = head_d;
                end else begin
                  popped_d  = back_q;
                  ram_raddr = ring_add(head_q, ADDR_W'(count_q - CNT_W'(2)));
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        // Merge the fetched end word and emit the pop result
        load_out   = 1'b1;
        o_popped_d = popped_q;
        if (!empty) begin
          if (front_take_q) begin
            front_d = ram_rdata;
          end else begin
            back_d = ram_rdata;
          end
        end
        o_front_d = empty ? '0 : front_d;
        o_back_d  = empty ? '0 : back_d;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      count_q      <= '0;
      front_take_q <= 1'b0;
      front_q      <= '0;
      back_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      count_q      <= count_d;
      front_take_q <= front_take_d;
      front_q      <= front_d;
      back_q       <= back_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    if (load_out) begin
      o_status_q <= o_status_d;
      o_popped_q <= o_popped_d;
      o_count_q  <= o_count_d;
      o_nempty_q <= o_nempty_d;
      o_front_q  <= o_front_d;
      o_back_q   <= o_back_d;
    end
  end

  // Drive the result beat
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, o_back_q, o_front_q, COUNT_W'(o_count_q), o_popped_q};
  assign m_axis_tuser_o  = {o_nempty_q, o_status_q};

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("deque count above capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register overwritten before taken");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE))
    else $error("read state held longer than one cycle");

  a_no_accept_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !s_axis_tready_o)
    else $error("input accepted while a pop is in flight");

  a_ram_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque: drives push and pop beats on the
// input stream and checks every result beat against an in-bench deque model.
// Depends on dq_pkg and the bounded_deque top level.

module testbench
  import dq_pkg::*;
();

  localparam int CLK_HALF_NS  = 5;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int HOLD_TICKS   = 400;

  // Fields of one result beat
  typedef struct {
    dq_status_e              status;
    logic signed [WORD_W-1:0] popped_value;
    logic [COUNT_W-1:0]      count;
    logic                    not_empty;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] back_value;
  } deque_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [WORD_W-1:0]     s_axis_tdata_i = '0;  // [31:0] value
  logic [KIND_W-1:0]     s_axis_tuser_i = '0;  // [1:0] kind
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // [31:0] popped_value, [42:32] count, [74:43] front_value,
  // [106:75] back_value, [111:107] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // [1:0] status, [2] not_empty
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  // Model of the deque contents, front at index 0
  logic signed [WORD_W-1:0] deque_words[$];
  deque_result_t            pending_results[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  bounded_deque dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #CLK_HALF_NS clk_i = ~clk_i;

  // Apply one operation to the model and return the result it must produce
  function automatic deque_result_t apply_deque_op(input dq_kind_e kind,
                                                   input logic signed [WORD_W-1:0] word);
    deque_result_t r;
    r.status       = STAT_OK;
    r.popped_value = '0;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (deque_words.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (kind == KIND_PUSH_FRONT) begin
          deque_words.insert(0, word);
        end else begin
          deque_words.insert(deque_words.size(), word);
        end
      end
      default: begin
        if (deque_words.size() == 0) begin
          r.status = STAT_EMPTY;
        end else if (kind == KIND_POP_FRONT) begin
          r.popped_value = deque_words[0];
          deque_words.delete(0);
        end else begin
          r.popped_value = deque_words[deque_words.size() - 1];
          deque_words.delete(deque_words.size() - 1);
        end
      end
    endcase
    r.count     = COUNT_W'(deque_words.size());
    r.not_empty = (deque_words.size() != 0);
    r.front_value = r.not_empty ? deque_words[0] : '0;
    r.back_value  = r.not_empty ? deque_words[$] : '0;
    return r;
  endfunction

  // Mostly random words, with the corner values mixed in
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and record its result
  task automatic send_item(input dq_kind_e kind, input logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tuser_i  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.insert(pending_results.size(), apply_deque_op(kind, word));
  endtask

  // Stop offering beats until every result has been taken
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Pops on an empty deque, pushes of the extreme words, single-word deque
  task automatic test_directed();
    send_item(KIND_POP_FRONT, pick_word());
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_PUSH_FRONT, 32'sh1234_5678);
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(KIND_POP_FRONT, pick_word());
    send_item(KIND_PUSH_BACK, 32'sh7FFF_FFFF);
    send_item(KIND_PUSH_FRONT, 32'sh8000_0000);
    send_item(KIND_PUSH_BACK, '0);
    send_item(KIND_PUSH_FRONT, -32'sd1);
    send_item(KIND_PUSH_BACK, 32'sh5555_AAAA);
    send_item(KIND_PUSH_FRONT, 32'shAAAA_5555);
    send_item(KIND_POP_FRONT, 32'shFFFF_FFFF);
    send_item(KIND_POP_BACK, '0);
    send_item(KIND_POP_FRONT, pick_word());
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_POP_FRONT, pick_word());
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_POP_FRONT, pick_word());
  endtask

  // Fill to capacity behind a long receiver hold, refuse pushes, then step
  // off and back onto the full level
  task automatic test_fill_and_refuse();
    hold_request = HOLD_TICKS;
    repeat (DEPTH) begin
      send_item($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
    end
    send_item(KIND_PUSH_FRONT, pick_word());
    send_item(KIND_PUSH_BACK, pick_word());
    wait_drained();
    send_item(KIND_POP_BACK, pick_word());
    send_item(KIND_PUSH_FRONT, pick_word());
    send_item(KIND_PUSH_BACK, pick_word());
    send_item(KIND_POP_FRONT, pick_word());
    send_item(KIND_POP_BACK, pick_word());
  endtask

  // Random mix; the push share changes every few dozen beats so the fill
  // level wanders
  task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
    int push_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    push_pct       = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if ($urandom_range(99) < push_pct) begin
        send_item($urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_word());
      end else begin
        send_item($urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK, pick_word());
      end
    end
  endtask

  // Drive result-side backpressure; a requested hold overrides random stalls
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each result beat against the oldest pending result
  always @(posedge clk_i) begin
    deque_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no pending operation");
        mismatches++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        check_field("status", want.status, m_axis_tuser_o[1:0]);
        check_field("not_empty", want.not_empty, m_axis_tuser_o[2]);
        check_field("popped_value", want.popped_value, $signed(m_axis_tdata_o[31:0]));
        check_field("count", want.count, m_axis_tdata_o[42:32]);
        check_field("front_value", want.front_value, $signed(m_axis_tdata_o[74:43]));
        check_field("back_value", want.back_value, $signed(m_axis_tdata_o[106:75]));
      end
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bounded_deque");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct  = 13;
    recv_stall_pct = 55;
    test_directed();
    test_fill_and_refuse();
    test_random(13, 55, 60);
    test_random(55, 13, 60);
    test_random(0, 0, 60);

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS bounded_deque");
    end else begin
      $display("FAIL bounded_deque");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dq_pkg.sv
design/dq_ram.sv
design/bounded_deque.sv
test/testbench.sv
